@@ hdl/obf_pkg.sv @@
// Shared types and constants for the look-at basis pipeline.
`timescale 1ns / 1ps

package obf_pkg;

  localparam int COMP_W = 16;   // Q4.12 input and Q1.14 output components
  localparam int VEC_W  = 17;   // components entering a normalizer
  localparam int SQ1_W  = 2 * COMP_W;
  localparam int SQ2_W  = 2 * VEC_W;
  localparam int S_W    = 36;   // sum of squares and divider remainder
  localparam int REM_W  = S_W + 1;
  localparam int QUO_W  = 29;   // quotient c*c*2^28 / s never exceeds 2^28
  localparam int ROOT_W = 15;   // square root of the quotient, at most 2^14
  localparam int RSQ_W  = 31;
  localparam int SIDE_W = 6 * COMP_W;
  localparam int THR_W  = 8;
  localparam int T2_W   = 2 * THR_W;
  localparam int T2Q_W  = T2_W + 4;
  localparam int FRAC_SH = 14;

  localparam logic [THR_W-1:0] THR_RESET = 8'd1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [VEC_W-1:0]  vcomp_t;

  localparam comp_t ONE_Q14  = 16'sd16384;
  localparam comp_t ZERO_Q14 = 16'sd0;

  // Control that travels with each word through a normalizer.
  typedef struct packed {
    logic valid;
    logic scale;
  } norm_ctl_t;

endpackage

@@ hdl/orthonormal_basis_from_forward.sv @@
// Top level of the look-at basis pipeline: forward and up unit vectors from a direction.
`timescale 1ns / 1ps

// Takes one Q4.12 look direction per word and returns the unit forward and unit
// up vectors in Q1.14, truncated toward zero. A new word is accepted every
// cycle unless the output is stalled. The depth is set by the three normalizers
// in series, each 46 stages deep (two stages of magnitude and square, 29 stages
// of bit-per-cycle division and 15 stages of bit-per-cycle square root), plus
// the cross-product and length stages around them. A stalled output holds the
// whole pipeline in place. The length threshold register resets to 1 and should
// be written only while the pipeline is empty.
module orthonormal_basis_from_forward (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [obf_pkg::THR_W-1:0]    length_threshold,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [obf_pkg::COMP_W-1:0] dir_x,
  input  logic signed [obf_pkg::COMP_W-1:0] dir_y,
  input  logic signed [obf_pkg::COMP_W-1:0] dir_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [obf_pkg::COMP_W-1:0] fwd_x,
  output logic signed [obf_pkg::COMP_W-1:0] fwd_y,
  output logic signed [obf_pkg::COMP_W-1:0] fwd_z,
  output logic signed [obf_pkg::COMP_W-1:0] up_x,
  output logic signed [obf_pkg::COMP_W-1:0] up_y,
  output logic signed [obf_pkg::COMP_W-1:0] up_z
);
  import obf_pkg::*;

  logic             en;
  logic [T2_W-1:0]  t2;
  logic [T2Q_W-1:0] t2q;

  // Direction length stages.
  logic             a0_v;
  comp_t            a0_d [3];
  logic             a1_v;
  comp_t            a1_d [3];
  logic [SQ1_W-1:0] a1_sq [3];
  norm_ctl_t        a2_ctl;
  vcomp_t           a2_c [3];
  logic [S_W-1:0]   a2_s;

  norm_ctl_t         n1_ctl;
  comp_t             n1_c [3];
  logic [SIDE_W-1:0] n1_side;

  // Right vector stages.
  logic             b0_v;
  comp_t            b0_f [3];
  logic             b1_v;
  comp_t            b1_f [3];
  logic [SQ1_W-1:0] b1_sq [3];
  norm_ctl_t        b2_ctl;
  comp_t            b2_f [3];
  vcomp_t           b2_r [3];
  logic [S_W-1:0]   b2_s;
  logic [S_W-1:0]   sa;
  logic [S_W-1:0]   sb;
  logic             alt;
  logic [S_W-1:0]   s_r;

  norm_ctl_t         n2_ctl;
  comp_t             n2_c [3];
  logic [SIDE_W-1:0] n2_side;

  // Up vector stages.
  logic                    c0_v;
  comp_t                   c0_f [3];
  comp_t                   c0_r [3];
  logic                    c1_v;
  comp_t                   c1_f [3];
  logic signed [SQ1_W-1:0] c1_p [6];
  logic                    c2_v;
  comp_t                   c2_f [3];
  vcomp_t                  c2_u [3];
  logic                    c3_v;
  comp_t                   c3_f [3];
  vcomp_t                  c3_u [3];
  logic [SQ2_W-1:0]        c3_sq [3];
  norm_ctl_t               c4_ctl;
  vcomp_t                  c4_u [3];
  logic [S_W-1:0]          c4_s;
  comp_t                   c4_f [3];
  logic signed [SQ1_W:0]   diff [3];
  logic signed [SQ1_W:0]   adj  [3];
  logic [S_W-1:0]          s_u;

  norm_ctl_t         n3_ctl;
  comp_t             n3_c [3];
  logic [SIDE_W-1:0] n3_side;

  // Whole pipeline advances together unless a finished word is held at the output.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2  <= T2_W'(THR_RESET) * T2_W'(THR_RESET);
      t2q <= T2Q_W'(THR_RESET) * T2Q_W'(THR_RESET) * T2Q_W'(16);
    end else if (cfg_valid) begin
      t2  <= T2_W'(length_threshold) * T2_W'(length_threshold);
      t2q <= {T2_W'(length_threshold) * T2_W'(length_threshold), 4'b0000};
    end
  end

  // Control path.
  always_ff @(posedge clk) begin
    if (rst) begin
      a0_v      <= 1'b0;
      a1_v      <= 1'b0;
      a2_ctl    <= '0;
      b0_v      <= 1'b0;
      b1_v      <= 1'b0;
      b2_ctl    <= '0;
      c0_v      <= 1'b0;
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      c3_v      <= 1'b0;
      c4_ctl    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      a0_v         <= in_valid;
      a1_v         <= a0_v;
      a2_ctl.valid <= a1_v;
      a2_ctl.scale <= (S_W'(a1_sq[0]) + S_W'(a1_sq[1]) + S_W'(a1_sq[2])) > S_W'(t2);
      b0_v         <= n1_ctl.valid;
      b1_v         <= b0_v;
      b2_ctl.valid <= b1_v;
      b2_ctl.scale <= s_r > S_W'(t2q);
      c0_v         <= n2_ctl.valid;
      c1_v         <= c0_v;
      c2_v         <= c1_v;
      c3_v         <= c2_v;
      c4_ctl.valid <= c3_v;
      c4_ctl.scale <= s_u > S_W'(t2q);
      out_valid    <= n3_ctl.valid;
    end
  end

  // Right is forward x world up, or forward x world X when that is too short.
  always_comb begin
    sa  = S_W'(b1_sq[2]) + S_W'(b1_sq[0]);
    sb  = S_W'(b1_sq[2]) + S_W'(b1_sq[1]);
    alt = sa < S_W'(t2q);
    s_r = alt ? sb : sa;
    s_u = S_W'(c3_sq[0]) + S_W'(c3_sq[1]) + S_W'(c3_sq[2]);
  end

  // Up is right x forward, truncated toward zero from Q2.28 to Q1.14.
  always_comb begin
    diff[0] = (SQ1_W+1)'(c1_p[0]) - (SQ1_W+1)'(c1_p[1]);
    diff[1] = (SQ1_W+1)'(c1_p[2]) - (SQ1_W+1)'(c1_p[3]);
    diff[2] = (SQ1_W+1)'(c1_p[4]) - (SQ1_W+1)'(c1_p[5]);
    for (int l = 0; l < 3; l++) begin
      adj[l] = diff[l] + (diff[l][SQ1_W] ? (SQ1_W+1)'((1 << FRAC_SH) - 1)
                                         : (SQ1_W+1)'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_d[0] <= dir_x;
      a0_d[1] <= dir_y;
      a0_d[2] <= dir_z;
      for (int l = 0; l < 3; l++) begin
        a1_d[l]  <= a0_d[l];
        a1_sq[l] <= a0_d[l] * a0_d[l];
        a2_c[l]  <= VEC_W'(a1_d[l]);
      end
      a2_s <= S_W'(a1_sq[0]) + S_W'(a1_sq[1]) + S_W'(a1_sq[2]);

      if (n1_ctl.scale) begin
        b0_f <= n1_c;
      end else begin
        b0_f[0] <= ZERO_Q14;
        b0_f[1] <= ZERO_Q14;
        b0_f[2] <= ONE_Q14;
      end
      for (int l = 0; l < 3; l++) begin
        b1_f[l]  <= b0_f[l];
        b1_sq[l] <= b0_f[l] * b0_f[l];
        b2_f[l]  <= b1_f[l];
      end
      if (alt) begin
        b2_r[0] <= '0;
        b2_r[1] <= VEC_W'(b1_f[2]);
        b2_r[2] <= -VEC_W'(b1_f[1]);
      end else begin
        b2_r[0] <= -VEC_W'(b1_f[2]);
        b2_r[1] <= '0;
        b2_r[2] <= VEC_W'(b1_f[0]);
      end
      b2_s <= s_r;

      c0_f[0] <= comp_t'(n2_side[SIDE_W-1 -: COMP_W]);
      c0_f[1] <= comp_t'(n2_side[SIDE_W-1-COMP_W -: COMP_W]);
      c0_f[2] <= comp_t'(n2_side[SIDE_W-1-2*COMP_W -: COMP_W]);
      if (n2_ctl.scale) begin
        c0_r <= n2_c;
      end else begin
        c0_r[0] <= comp_t'(n2_side[3*COMP_W-1 -: COMP_W]);
        c0_r[1] <= comp_t'(n2_side[2*COMP_W-1 -: COMP_W]);
        c0_r[2] <= comp_t'(n2_side[COMP_W-1 -: COMP_W]);
      end
      c1_p[0] <= c0_r[1] * c0_f[2];
      c1_p[1] <= c0_r[2] * c0_f[1];
      c1_p[2] <= c0_r[2] * c0_f[0];
      c1_p[3] <= c0_r[0] * c0_f[2];
      c1_p[4] <= c0_r[0] * c0_f[1];
      c1_p[5] <= c0_r[1] * c0_f[0];
      for (int l = 0; l < 3; l++) begin
        c1_f[l]  <= c0_f[l];
        c2_f[l]  <= c1_f[l];
        c2_u[l]  <= VEC_W'(adj[l] >>> FRAC_SH);
        c3_f[l]  <= c2_f[l];
        c3_u[l]  <= c2_u[l];
        c3_sq[l] <= c2_u[l] * c2_u[l];
        c4_f[l]  <= c3_f[l];
        c4_u[l]  <= c3_u[l];
      end
      c4_s <= s_u;

      fwd_x <= comp_t'(n3_side[SIDE_W-1 -: COMP_W]);
      fwd_y <= comp_t'(n3_side[SIDE_W-1-COMP_W -: COMP_W]);
      fwd_z <= comp_t'(n3_side[SIDE_W-1-2*COMP_W -: COMP_W]);
      if (n3_ctl.scale) begin
        up_x <= n3_c[0];
        up_y <= n3_c[1];
        up_z <= n3_c[2];
      end else begin
        up_x <= ZERO_Q14;
        up_y <= ONE_Q14;
        up_z <= ZERO_Q14;
      end
    end
  end

  obf_norm u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (a2_ctl),
    .in_c     (a2_c),
    .in_s     (a2_s),
    .in_side  ({SIDE_W{1'b0}}),
    .out_ctl  (n1_ctl),
    .out_c    (n1_c),
    .out_side (n1_side)
  );

  obf_norm u_norm_right (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (b2_ctl),
    .in_c     (b2_r),
    .in_s     (b2_s),
    .in_side  ({b2_f[0], b2_f[1], b2_f[2],
                COMP_W'(b2_r[0]), COMP_W'(b2_r[1]), COMP_W'(b2_r[2])}),
    .out_ctl  (n2_ctl),
    .out_c    (n2_c),
    .out_side (n2_side)
  );

  obf_norm u_norm_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (c4_ctl),
    .in_c     (c4_u),
    .in_s     (c4_s),
    .in_side  ({c4_f[0], c4_f[1], c4_f[2], {(3*COMP_W){1'b0}}}),
    .out_ctl  (n3_ctl),
    .out_c    (n3_c),
    .out_side (n3_side)
  );

  // The forward word at the output is never the all-zero vector.
  a_fwd_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fwd_x == 0 && fwd_y == 0 && fwd_z == 0))
    else $error("forward word is the zero vector");

  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fwd_x <= ONE_Q14 && fwd_x >= -ONE_Q14 &&
                   fwd_y <= ONE_Q14 && fwd_y >= -ONE_Q14 &&
                   fwd_z <= ONE_Q14 && fwd_z >= -ONE_Q14))
    else $error("forward component outside unit range");

  a_up_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (up_x <= ONE_Q14 && up_x >= -ONE_Q14 &&
                   up_y <= ONE_Q14 && up_y >= -ONE_Q14 &&
                   up_z <= ONE_Q14 && up_z >= -ONE_Q14))
    else $error("up component outside unit range");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

endmodule

@@ hdl/obf_norm.sv @@
// Three-lane pipelined normalizer: c * 2^14 / sqrt(s), truncated toward zero.
`timescale 1ns / 1ps

module obf_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  obf_pkg::norm_ctl_t          in_ctl,
  input  obf_pkg::vcomp_t             in_c [3],
  input  logic [obf_pkg::S_W-1:0]     in_s,
  input  logic [obf_pkg::SIDE_W-1:0]  in_side,
  output obf_pkg::norm_ctl_t          out_ctl,
  output obf_pkg::comp_t              out_c [3],
  output logic [obf_pkg::SIDE_W-1:0]  out_side
);
  import obf_pkg::*;

  // Magnitude stage.
  norm_ctl_t         p0_ctl;
  logic [VEC_W-1:0]  p0_mag  [3];
  logic              p0_neg  [3];
  logic [S_W-1:0]    p0_s;
  logic [SIDE_W-1:0] p0_side;

  // Square stage.
  norm_ctl_t         p1_ctl;
  logic [S_W-1:0]    p1_rem  [3];
  logic              p1_lsb  [3];
  logic              p1_neg  [3];
  logic [S_W-1:0]    p1_s;
  logic [SIDE_W-1:0] p1_side;

  // Restoring divider, one quotient bit per stage.
  norm_ctl_t         d_ctl   [QUO_W];
  logic [S_W-1:0]    d_rem   [QUO_W][3];
  logic [QUO_W-1:0]  d_q     [QUO_W][3];
  logic              d_neg   [QUO_W][3];
  logic [S_W-1:0]    d_s     [QUO_W];
  logic [SIDE_W-1:0] d_side  [QUO_W];
  logic [S_W-1:0]    dn_rem  [QUO_W][3];
  logic [QUO_W-1:0]  dn_q    [QUO_W][3];

  // Square root, one root bit per stage.
  norm_ctl_t         r_ctl   [ROOT_W];
  logic [QUO_W-1:0]  r_q     [ROOT_W][3];
  logic [ROOT_W-1:0] r_root  [ROOT_W][3];
  logic [RSQ_W-1:0]  r_sq    [ROOT_W][3];
  logic              r_neg   [ROOT_W][3];
  logic [SIDE_W-1:0] r_side  [ROOT_W];
  logic [ROOT_W-1:0] rn_root [ROOT_W][3];
  logic [RSQ_W-1:0]  rn_sq   [ROOT_W][3];

  logic [SQ2_W-1:0]  mag_sq  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_sq[l] = p0_mag[l] * p0_mag[l];
    end
  end

  always_comb begin
    logic [REM_W-1:0] rsh;
    logic [QUO_W-1:0] qin;
    logic [S_W-1:0]   ssrc;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          rsh  = {p1_rem[l], p1_lsb[l]};
          qin  = '0;
          ssrc = p1_s;
        end else begin
          rsh  = {d_rem[k-1][l], 1'b0};
          qin  = d_q[k-1][l];
          ssrc = d_s[k-1];
        end
        ge = (rsh >= {1'b0, ssrc});
        dn_rem[k][l] = ge ? S_W'(rsh - {1'b0, ssrc}) : S_W'(rsh);
        dn_q[k][l]   = {qin[QUO_W-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0]  qsrc;
    logic [ROOT_W-1:0] root;
    logic [RSQ_W-1:0]  sq;
    logic [RSQ_W-1:0]  trial;
    for (int j = 0; j < ROOT_W; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          qsrc = d_q[QUO_W-1][l];
          root = '0;
          sq   = '0;
        end else begin
          qsrc = r_q[j-1][l];
          root = r_root[j-1][l];
          sq   = r_sq[j-1][l];
        end
        // (root + 2^b)^2 = root^2 + root * 2^(b+1) + 2^(2b)
        trial = sq + (RSQ_W'(root) << (ROOT_W - j)) +
                (RSQ_W'(1) << (2 * (ROOT_W - 1 - j)));
        if (trial <= RSQ_W'(qsrc)) begin
          rn_root[j][l] = root | (ROOT_W'(1) << (ROOT_W - 1 - j));
          rn_sq[j][l]   = trial;
        end else begin
          rn_root[j][l] = root;
          rn_sq[j][l]   = sq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_ctl <= '0;
      p1_ctl <= '0;
      for (int k = 0; k < QUO_W; k++) d_ctl[k] <= '0;
      for (int j = 0; j < ROOT_W; j++) r_ctl[j] <= '0;
    end else if (en) begin
      p0_ctl   <= in_ctl;
      p1_ctl   <= p0_ctl;
      d_ctl[0] <= p1_ctl;
      for (int k = 1; k < QUO_W; k++) d_ctl[k] <= d_ctl[k-1];
      r_ctl[0] <= d_ctl[QUO_W-1];
      for (int j = 1; j < ROOT_W; j++) r_ctl[j] <= r_ctl[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_s    <= in_s;
      p0_side <= in_side;
      p1_s    <= p0_s;
      p1_side <= p0_side;
      for (int l = 0; l < 3; l++) begin
        p0_neg[l] <= in_c[l][VEC_W-1];
        p0_mag[l] <= in_c[l][VEC_W-1] ? VEC_W'(-in_c[l]) : VEC_W'(in_c[l]);
        p1_rem[l] <= S_W'(mag_sq[l] >> 1);
        p1_lsb[l] <= mag_sq[l][0];
        p1_neg[l] <= p0_neg[l];
      end
      for (int k = 0; k < QUO_W; k++) begin
        d_s[k]    <= (k == 0) ? p1_s : d_s[k-1];
        d_side[k] <= (k == 0) ? p1_side : d_side[k-1];
        for (int l = 0; l < 3; l++) begin
          d_rem[k][l] <= dn_rem[k][l];
          d_q[k][l]   <= dn_q[k][l];
          d_neg[k][l] <= (k == 0) ? p1_neg[l] : d_neg[k-1][l];
        end
      end
      for (int j = 0; j < ROOT_W; j++) begin
        r_side[j] <= (j == 0) ? d_side[QUO_W-1] : r_side[j-1];
        for (int l = 0; l < 3; l++) begin
          r_q[j][l]    <= (j == 0) ? d_q[QUO_W-1][l] : r_q[j-1][l];
          r_neg[j][l]  <= (j == 0) ? d_neg[QUO_W-1][l] : r_neg[j-1][l];
          r_root[j][l] <= rn_root[j][l];
          r_sq[j][l]   <= rn_sq[j][l];
        end
      end
    end
  end

  assign out_ctl  = r_ctl[ROOT_W-1];
  assign out_side = r_side[ROOT_W-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_c[l] = r_neg[ROOT_W-1][l] ? -comp_t'({1'b0, r_root[ROOT_W-1][l]})
                                    :  comp_t'({1'b0, r_root[ROOT_W-1][l]});
    end
  end

endmodule

@@ sim/orthonormal_basis_from_forward_tb.sv @@
// Self-checking testbench for the look-at basis pipeline with a built-in predictor.
`timescale 1ns / 1ps

module orthonormal_basis_from_forward_tb;
  import obf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int CFG_SETTLE     = 160;

  typedef struct packed {
    comp_t fx, fy, fz, ux, uy, uz;
  } basis_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [THR_W-1:0]  length_threshold = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  comp_t             dir_x = '0, dir_y = '0, dir_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  comp_t             fwd_x, fwd_y, fwd_z, up_x, up_y, up_z;

  basis_t            expected_basis[$];
  int unsigned       thr_model = THR_RESET;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_left = 0;
  int                errors = 0;
  int                quiet_cycles = 0;

  orthonormal_basis_from_forward dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .length_threshold(length_threshold),
    .in_valid(in_valid), .in_ready(in_ready),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned sum_squares(longint a, longint b, longint c);
    return longint'(a * a) + longint'(b * b) + longint'(c * c);
  endfunction

  // Largest q with q*q*s <= c*c*2^28, which is c*2^14/sqrt(s) truncated.
  function automatic longint unit_q14(longint c, longint unsigned s);
    longint unsigned mag, target, lo, hi, mid;
    mag = (c < 0) ? -c : c;
    target = (mag * mag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * s <= target) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -longint'(lo) : longint'(lo);
  endfunction

  function automatic basis_t look_at_basis(comp_t dx, comp_t dy, comp_t dz,
                                           int unsigned thr);
    longint unsigned t2, t2q, s;
    longint fx, fy, fz, rx, ry, rz, ux, uy, uz;
    basis_t b;
    t2  = thr * thr;
    t2q = 16 * t2;
    s = sum_squares(dx, dy, dz);
    if (s > t2) begin
      fx = unit_q14(dx, s); fy = unit_q14(dy, s); fz = unit_q14(dz, s);
    end else begin
      fx = 0; fy = 0; fz = 16384;
    end
    rx = -fz; ry = 0; rz = fx;
    s = sum_squares(rx, ry, rz);
    // Looking almost straight up or down: use world X instead of world up.
    if (s < t2q) begin
      rx = 0; ry = fz; rz = -fy;
      s = sum_squares(rx, ry, rz);
    end
    if (s > t2q) begin
      rx = unit_q14(rx, s); ry = unit_q14(ry, s); rz = unit_q14(rz, s);
    end
    ux = (ry * fz - rz * fy) / 16384;
    uy = (rz * fx - rx * fz) / 16384;
    uz = (rx * fy - ry * fx) / 16384;
    s = sum_squares(ux, uy, uz);
    if (s > t2q) begin
      ux = unit_q14(ux, s); uy = unit_q14(uy, s); uz = unit_q14(uz, s);
    end else begin
      ux = 0; uy = 16384; uz = 0;
    end
    b.fx = fx[15:0]; b.fy = fy[15:0]; b.fz = fz[15:0];
    b.ux = ux[15:0]; b.uy = uy[15:0]; b.uz = uz[15:0];
    return b;
  endfunction

  task automatic report_mismatch(string field, comp_t got, comp_t want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Result side: random stalls, long hold-offs and the field-by-field check.
  always @(posedge clk) begin
    basis_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_basis.size() == 0) begin
          $display("unexpected result word at %0t", $realtime);
          errors++;
        end else begin
          want = expected_basis.pop_front();
          if (fwd_x !== want.fx) report_mismatch("fwd_x", fwd_x, want.fx);
          if (fwd_y !== want.fy) report_mismatch("fwd_y", fwd_y, want.fy);
          if (fwd_z !== want.fz) report_mismatch("fwd_z", fwd_z, want.fz);
          if (up_x !== want.ux) report_mismatch("up_x", up_x, want.ux);
          if (up_y !== want.uy) report_mismatch("up_y", up_y, want.uy);
          if (up_z !== want.uz) report_mismatch("up_z", up_z, want.uz);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // The watchdog counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL orthonormal_basis_from_forward");
      $finish;
    end
  end

  // Each cycle before the word is offered idles with the sender's percentage.
  task automatic send_dir(comp_t x, comp_t y, comp_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk); while (!in_ready);
    expected_basis.push_back(look_at_basis(x, y, z, thr_model));
  endtask

  // Waits for the pipeline to empty, then writes the threshold register.
  task automatic write_threshold(logic [THR_W-1:0] value);
    in_valid <= 1'b0;
    wait (expected_basis.size() == 0);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    length_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = value;
  endtask

  function automatic comp_t rand_in(int lim);
    return comp_t'($urandom_range(2 * lim) - lim);
  endfunction

  // Mix of full-range vectors, vectors near the threshold, near-vertical ones and ones within +-4096.
  task automatic send_random_dir();
    case ($urandom_range(3))
      0: send_dir(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
      1: send_dir(rand_in(2 * thr_model + 2), rand_in(2 * thr_model + 2),
                  rand_in(2 * thr_model + 2));
      2: send_dir(rand_in(64), comp_t'($urandom), rand_in(64));
      default: send_dir(rand_in(4096), rand_in(4096), rand_in(4096));
    endcase
  endtask

  task automatic test_directed();
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sd1, 16'sd0, 16'sd0);
    send_dir(16'sd1, 16'sd1, 16'sd0);
    send_dir(16'sd32767, 16'sd0, 16'sd0);
    send_dir(-16'sd32768, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd32767, 16'sd0);
    send_dir(16'sd0, -16'sd32768, 16'sd0);
    send_dir(16'sd0, 16'sd0, 16'sd32767);
    send_dir(16'sd0, 16'sd0, -16'sd32768);
    send_dir(16'sd32767, 16'sd32767, 16'sd32767);
    send_dir(-16'sd32768, -16'sd32768, -16'sd32768);
    send_dir(16'sd1, 16'sd4096, 16'sd0);
    send_dir(16'sd0, -16'sd4096, 16'sd1);
    send_dir(16'sd3, 16'sd4096, -16'sd2);
    send_dir(16'sd4096, 16'sd4096, 16'sd0);
    send_dir(-16'sd1, 16'sd0, 16'sd4096);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(8'd0);
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd0, -16'sd1);
    send_dir(16'sd0, 16'sd1, 16'sd0);
    repeat (30) send_random_dir();
    write_threshold(8'd255);
    send_dir(16'sd255, 16'sd0, 16'sd0);
    send_dir(16'sd256, 16'sd0, 16'sd0);
    send_dir(16'sd147, 16'sd147, 16'sd148);
    send_dir(16'sd3, 16'sd4000, 16'sd3);
    send_dir(16'sd20, 16'sd4000, -16'sd20);
    repeat (40) send_random_dir();
    write_threshold(8'd37);
    repeat (30) send_random_dir();
  endtask

  task automatic test_random_phase(int sender_pct, int receiver_pct, int count);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) send_random_dir();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    repeat (250) send_random_dir();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    write_threshold(8'd1);
    test_random_phase(18, 75, 200);
    test_random_phase(75, 18, 200);
    test_random_phase(0, 0, 200);
    test_backpressure();
    in_valid <= 1'b0;
    wait (expected_basis.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS orthonormal_basis_from_forward");
    else
      $display("FAIL orthonormal_basis_from_forward");
    $finish;
  end

endmodule
